/* rtl/qyu_pkg.sv */
// Shared constants, arctangent table and types for the yaw unwrap block.
package qyu_pkg;

    // Fixed widths of the datapath
    localparam int VEC_W  = 40;  // vectoring x/y, Q28 operands plus growth
    localparam int ROT_W  = 34;  // rotation x/y, Q30 cosine and sine
    localparam int ANG_W  = 36;  // angle accumulators, Q30 radians
    localparam int RAW_W  = 19;  // raw heading, 2^-16 rad
    localparam int CFG_W  = 19;
    localparam int TURN_W = 14;
    localparam int TAB_LEN = 30;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam int     TURN_Q16    = 411775;
    localparam int     TURN_LIMIT  = 4096;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_MOUNT_X   = 2'd0;
    localparam logic [1:0] CFG_MOUNT_Y   = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic signed [CFG_W-1:0] MOUNT_X_RESET   = -19'sd13786;
    localparam logic signed [CFG_W-1:0] MOUNT_Y_RESET   = 19'sd0;
    localparam logic        [CFG_W-1:0] THRESHOLD_RESET = 19'd196608;

    // atan(2^-i) in Q30, truncated up to i = 26; the last three entries are rounded
    localparam longint ATAN_Q30 [TAB_LEN] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 8, 4, 2
    };

    // Result of the unwrap stage
    typedef struct packed {
        logic signed [31:0]       heading;
        logic signed [TURN_W-1:0] turns;
        logic signed [RAW_W-1:0]  raw;
    } unwrap_t;

endpackage

/* rtl/qyu_cell.sv */
// One CORDIC micro-rotation cell; vectoring or rotation mode.
module qyu_cell import qyu_pkg::*; #(
    parameter int     W         = 40,
    parameter int     ZW        = 36,
    parameter int     SHIFT     = 0,
    parameter bit     VECTORING = 1'b1,
    parameter longint ATAN      = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vld_in,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic                 vld_out,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out
);

    localparam logic signed [ZW-1:0] ATAN_W = ZW'(ATAN);

    logic                 vld_reg;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 up;

    // Pick the direction and do one shift-add step
    always_comb
    begin
        up = VECTORING ? (y_in > 0) : (z_in < 0);
        if (up)
        begin
            x_next = x_in + (y_in >>> SHIFT);
            y_next = y_in - (x_in >>> SHIFT);
            z_next = z_in + ATAN_W;
        end
        else
        begin
            x_next = x_in - (y_in >>> SHIFT);
            y_next = y_in + (x_in >>> SHIFT);
            z_next = z_in - ATAN_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign vld_out = vld_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

/* rtl/qyu_unwrap.sv */
// Raw heading rounding and turn-count unwrap with saturation.
module qyu_unwrap import qyu_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    vld_in,
    input  logic signed [ANG_W-1:0] z_in,
    input  logic                    zero_in,
    input  logic        [CFG_W-1:0] threshold,
    output logic                    vld_out,
    output unwrap_t                 result
);

    localparam logic signed [33:0] TURN_W34  = 34'(TURN_Q16);
    localparam logic signed [TURN_W-1:0] LIM = TURN_W'(TURN_LIMIT);

    logic                      v1_reg, v2_reg;
    logic signed [RAW_W-1:0]   raw_reg, raw2_reg;
    logic signed [ANG_W-1:0]   rounded;
    logic signed [TURN_W-1:0]  turn_reg, turn_next;
    logic signed [31:0]        off_reg, off_next;
    logic signed [31:0]        last_reg, last_next;
    logic signed [33:0]        head, diff, thr;

    // Round the Q30 angle half up to 2^-16 rad
    assign rounded = (z_in + ANG_W'(8192)) >>> 14;

    always_ff @(posedge clk)
    begin
        if (vld_in)
            raw_reg <= zero_in ? '0 : rounded[RAW_W-1:0];
    end

    // Add whole turns and detect a wrap against the previous heading
    always_comb
    begin
        head      = 34'(raw_reg) + 34'(off_reg);
        diff      = head - 34'(last_reg);
        thr       = {15'd0, threshold};
        turn_next = turn_reg;
        off_next  = off_reg;
        if (diff < -thr)
        begin
            if (turn_reg < LIM)
            begin
                turn_next = turn_reg + TURN_W'(1);
                off_next  = off_reg + 32'(TURN_Q16);
                head      = head + TURN_W34;
            end
        end
        else if (diff > thr)
        begin
            if (turn_reg > -LIM)
            begin
                turn_next = turn_reg - TURN_W'(1);
                off_next  = off_reg - 32'(TURN_Q16);
                head      = head - TURN_W34;
            end
        end
        last_next = head[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            turn_reg <= '0;
            off_reg  <= '0;
            last_reg <= '0;
        end
        else
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
            if (v1_reg)
            begin
                turn_reg <= turn_next;
                off_reg  <= off_next;
                last_reg <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
            raw2_reg <= raw_reg;
    end

    assign vld_out        = v2_reg;
    assign result.heading = last_reg;
    assign result.turns   = turn_reg;
    assign result.raw     = raw2_reg;

endmodule

/* rtl/quaternion_yaw_unwrap_base_pose.sv */
// One input word is in work at a time. After a word is accepted, s_axis_tready
// stays low until its result, passed through two chains of CORDIC_STEPS cells
// (vectoring for atan2, rotation for cos/sin), is loaded into the output
// register; a stalled output word holds off that load until it is taken.
// Reset (async, low) clears turn count, last heading and handshake state and
// loads the mount offsets and jump threshold with their defaults.
// Top level: pose sample to base origin with unwrapped heading.
module quaternion_yaw_unwrap_base_pose import qyu_pkg::*; #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // trans_x, trans_y, trans_z, quat_w, quat_x, quat_y, quat_z
    input  logic [159:0]       s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // base_x, base_y, base_z, heading, turns, 2 zero pad bits
    output logic [143:0]       m_axis_tdata,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int N = CORDIC_STEPS;

    // Configuration registers
    logic signed [CFG_W-1:0] mx_reg, my_reg;
    logic        [CFG_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mx_reg  <= MOUNT_X_RESET;
            my_reg  <= MOUNT_Y_RESET;
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MOUNT_X:   mx_reg  <= cfg_data;
                CFG_MOUNT_Y:   my_reg  <= cfg_data;
                CFG_THRESHOLD: thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: hold translation, form quaternion products
    logic               busy_reg, v0_reg, in_acc;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    logic signed [31:0] pxz_reg, pwy_reg, pxx_reg, pyy_reg;
    logic signed [15:0] qw, qx, qy, qz;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_reg;
    assign qw = s_axis_tdata[111:96];
    assign qx = s_axis_tdata[127:112];
    assign qy = s_axis_tdata[143:128];
    assign qz = s_axis_tdata[159:144];

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            tx_reg  <= s_axis_tdata[31:0];
            ty_reg  <= s_axis_tdata[63:32];
            tz_reg  <= s_axis_tdata[95:64];
            pxz_reg <= qx * qz;
            pwy_reg <= qw * qy;
            pxx_reg <= qx * qx;
            pyy_reg <= qy * qy;
        end
    end

    // atan2 operands in Q28 and quarter-turn pre-rotation
    logic signed [VEC_W-1:0] ay, ax;
    logic signed [VEC_W-1:0] vx [0:N];
    logic signed [VEC_W-1:0] vy [0:N];
    logic signed [ANG_W-1:0] vz [0:N];
    logic                    vv [0:N];
    logic                    zero_vec;

    always_comb
    begin
        ay = (VEC_W'(pxz_reg) + VEC_W'(pwy_reg)) <<< 1;
        ax = (VEC_W'(1) <<< 28) - ((VEC_W'(pxx_reg) + VEC_W'(pyy_reg)) <<< 1);
        vv[0] = v0_reg;
        if (ax < 0)
        begin
            if (ay >= 0)
            begin
                vx[0] = ay;
                vy[0] = -ax;
                vz[0] = ANG_W'(HALF_PI_Q30);
            end
            else
            begin
                vx[0] = -ay;
                vy[0] = ax;
                vz[0] = -ANG_W'(HALF_PI_Q30);
            end
        end
        else
        begin
            vx[0] = ax;
            vy[0] = ay;
            vz[0] = '0;
        end
    end

    assign zero_vec = (ax == '0) && (ay == '0);

    // Vectoring chain
    for (genvar i = 0; i < N; i++)
    begin : g_vec
        qyu_cell #(
            .W(VEC_W), .ZW(ANG_W), .SHIFT(i), .VECTORING(1'b1), .ATAN(ATAN_Q30[i])
        ) u_cell (
            .clk(clk), .rst_n(rst_n),
            .vld_in(vv[i]), .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
            .vld_out(vv[i+1]), .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
        );
    end

    // Round and unwrap
    logic    uw_vld;
    unwrap_t uw;

    qyu_unwrap u_unwrap (
        .clk(clk), .rst_n(rst_n),
        .vld_in(vv[N]), .z_in(vz[N]), .zero_in(zero_vec),
        .threshold(thr_reg),
        .vld_out(uw_vld), .result(uw)
    );

    // Rotation chain from the raw heading
    logic signed [ROT_W-1:0] rx [0:N];
    logic signed [ROT_W-1:0] ry [0:N];
    logic signed [ANG_W-1:0] rz [0:N];
    logic                    rv [0:N];
    logic signed [ANG_W-1:0] ang;

    always_comb
    begin
        ang   = ANG_W'(uw.raw) <<< 14;
        rv[0] = uw_vld;
        if (ang > ANG_W'(HALF_PI_Q30))
        begin
            rx[0] = '0;
            ry[0] = ROT_W'(GAIN_Q30);
            rz[0] = ang - ANG_W'(HALF_PI_Q30);
        end
        else if (ang < -ANG_W'(HALF_PI_Q30))
        begin
            rx[0] = '0;
            ry[0] = -ROT_W'(GAIN_Q30);
            rz[0] = ang + ANG_W'(HALF_PI_Q30);
        end
        else
        begin
            rx[0] = ROT_W'(GAIN_Q30);
            ry[0] = '0;
            rz[0] = ang;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        qyu_cell #(
            .W(ROT_W), .ZW(ANG_W), .SHIFT(i), .VECTORING(1'b0), .ATAN(ATAN_Q30[i])
        ) u_cell (
            .clk(clk), .rst_n(rst_n),
            .vld_in(rv[i]), .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]),
            .vld_out(rv[i+1]), .x_out(rx[i+1]), .y_out(ry[i+1]), .z_out(rz[i+1])
        );
    end

    // Rotate the mount offset: products, then round, then sums
    localparam int PW = ROT_W + CFG_W;
    logic                    m_vld_reg, r_vld_reg, res_vld_reg;
    logic signed [PW-1:0]    cmx_reg, smy_reg, smx_reg, cmy_reg;
    logic signed [PW:0]      sum_x, sum_y;
    logic signed [PW:0]      rotx_full, roty_full;
    logic signed [24:0]      rotx_reg, roty_reg;
    logic signed [33:0]      bx, by;
    logic signed [31:0]      bx_reg, by_reg;

    always_comb
    begin
        sum_x     = (PW+1)'(cmx_reg) - (PW+1)'(smy_reg) + ((PW+1)'(1) <<< 29);
        sum_y     = (PW+1)'(smx_reg) + (PW+1)'(cmy_reg) + ((PW+1)'(1) <<< 29);
        rotx_full = sum_x >>> 30;
        roty_full = sum_y >>> 30;
        bx = 34'(tz_reg) + 34'(mx_reg) - 34'(rotx_reg);
        by = 34'(tx_reg) + 34'(my_reg) - 34'(roty_reg);
    end

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (rv[N])
        begin
            cmx_reg <= PW'(rx[N]) * PW'(mx_reg);
            smy_reg <= PW'(ry[N]) * PW'(my_reg);
            smx_reg <= PW'(ry[N]) * PW'(mx_reg);
            cmy_reg <= PW'(rx[N]) * PW'(my_reg);
        end
        if (m_vld_reg)
        begin
            rotx_reg <= rotx_full[24:0];
            roty_reg <= roty_full[24:0];
        end
        if (r_vld_reg)
        begin
            bx_reg <= sat32(bx);
            by_reg <= sat32(by);
        end
    end

    // Control: one item in work, output register parts the two sides
    logic out_load;
    assign out_load = res_vld_reg && (!m_axis_tvalid || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            v0_reg        <= 1'b0;
            m_vld_reg     <= 1'b0;
            r_vld_reg     <= 1'b0;
            res_vld_reg   <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            v0_reg    <= in_acc;
            m_vld_reg <= rv[N];
            r_vld_reg <= m_vld_reg;
            if (in_acc)
                busy_reg <= 1'b1;
            else if (out_load)
                busy_reg <= 1'b0;
            if (r_vld_reg)
                res_vld_reg <= 1'b1;
            else if (out_load)
                res_vld_reg <= 1'b0;
            if (out_load)
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    // Pack the result word
    always_ff @(posedge clk)
    begin
        if (out_load)
            m_axis_tdata <= {2'b00, uw.turns, uw.heading, ty_reg, by_reg, bx_reg};
    end

endmodule

/* rtl/qyu_checker.sv */
// Port-level checks for the yaw unwrap block, bound to the top level.
module qyu_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);

    // Hold a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

    // Drop ready after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after accept");

    // Keep the turn count within its limits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[141:128]) <= 14'sd4096)
                       && ($signed(m_axis_tdata[141:128]) >= -14'sd4096))
    else $error("turn count out of range");

    // Keep the pad bits at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[143:142] == 2'b00)
    else $error("pad bits set");

endmodule

bind quaternion_yaw_unwrap_base_pose qyu_checker u_qyu_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

/* dv/tb_quaternion_yaw_unwrap_base_pose.sv */
// Testbench for the pose-to-base converter with heading unwrap.
`timescale 1ns / 100ps

module tb_quaternion_yaw_unwrap_base_pose;
    import qyu_pkg::*;

    typedef struct {
        logic signed [31:0] tx, ty, tz;
        logic signed [15:0] qw, qx, qy, qz;
    } pose_t;

    typedef struct {
        logic signed [31:0] bx, by, bz, hd;
        logic signed [13:0] tn;
    } base_t;

    // Expected base origins, heading unwrap state and register copy
    class pose_scoreboard;
        base_t  pending[$];
        longint mx = MOUNT_X_RESET;
        longint my = MOUNT_Y_RESET;
        longint thr = THRESHOLD_RESET;
        longint turn_cnt = 0;
        longint prev_heading = 0;
        int     errors = 0;

        function longint shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint heading_of(longint y, longint x);
            longint z, t, dx, dy;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                if (y >= 0) begin t = x; x = y; y = -t; z = HALF_PI_Q30; end
                else begin t = x; x = -y; y = t; z = -HALF_PI_Q30; end
            end
            for (int i = 0; i < 18; i++) begin
                dx = shr(y, i);
                dy = shr(x, i);
                if (y > 0) begin x += dx; y -= dy; z += ATAN_Q30[i]; end
                else begin x -= dx; y += dy; z -= ATAN_Q30[i]; end
            end
            return shr(z + 8192, 14);
        endfunction

        function void cos_sin(longint a, output longint c, output longint s);
            longint x, y, dx, dy;
            x = GAIN_Q30;
            y = 0;
            if (a > HALF_PI_Q30) begin x = 0; y = GAIN_Q30; a -= HALF_PI_Q30; end
            else if (a < -HALF_PI_Q30) begin x = 0; y = -GAIN_Q30; a += HALF_PI_Q30; end
            for (int i = 0; i < 18; i++) begin
                dx = shr(y, i);
                dy = shr(x, i);
                if (a >= 0) begin x -= dx; y += dy; a -= ATAN_Q30[i]; end
                else begin x += dx; y -= dy; a += ATAN_Q30[i]; end
            end
            c = x;
            s = y;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_MOUNT_X) mx = longint'($signed(val));
            else if (idx == CFG_MOUNT_Y) my = longint'($signed(val));
            else if (idx == CFG_THRESHOLD) thr = longint'(val);
        endfunction

        // Advance the unwrap state and queue the expected word
        function void note_pose(pose_t p);
            longint ay, ax, raw, hd, diff, c, s, rx, ry;
            base_t e;
            ay = 2 * (longint'(p.qx) * p.qz + longint'(p.qw) * p.qy);
            ax = (64'sd1 <<< 28) - 2 * (longint'(p.qx) * p.qx + longint'(p.qy) * p.qy);
            raw = heading_of(ay, ax);
            hd = raw + turn_cnt * TURN_Q16;
            diff = hd - prev_heading;
            if (diff < -thr) begin
                if (turn_cnt < TURN_LIMIT) begin turn_cnt++; hd += TURN_Q16; end
            end else if (diff > thr) begin
                if (turn_cnt > -TURN_LIMIT) begin turn_cnt--; hd -= TURN_Q16; end
            end
            prev_heading = hd;
            cos_sin(raw * 16384, c, s);
            rx = shr(c * mx - s * my + (64'sd1 <<< 29), 30);
            ry = shr(s * mx + c * my + (64'sd1 <<< 29), 30);
            e.bx = clip32(longint'(p.tz) + mx - rx);
            e.by = clip32(longint'(p.tx) + my - ry);
            e.bz = p.ty;
            e.hd = hd[31:0];
            e.tn = turn_cnt[13:0];
            pending.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_word(logic [143:0] d);
            base_t e;
            if (pending.size() == 0) begin
                report("extra word", 1, 0);
                return;
            end
            e = pending.pop_front();
            if ($signed(d[31:0]) != e.bx) report("base_x", $signed(d[31:0]), e.bx);
            if ($signed(d[63:32]) != e.by) report("base_y", $signed(d[63:32]), e.by);
            if ($signed(d[95:64]) != e.bz) report("base_z", $signed(d[95:64]), e.bz);
            if ($signed(d[127:96]) != e.hd) report("heading", $signed(d[127:96]), e.hd);
            if ($signed(d[141:128]) != e.tn) report("turns", $signed(d[141:128]), e.tn);
        endtask
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               s_axis_tvalid = 0;
    logic               s_axis_tready;
    logic [159:0]       s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 0;
    logic [143:0]       m_axis_tdata;
    logic               cfg_we = 0;
    logic [1:0]         cfg_addr = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    pose_scoreboard     sb = new();

    quaternion_yaw_unwrap_base_pose u_top (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Check every accepted output word
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);
    end

    // Random ready with gaps
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            repeat (gap) @(negedge clk);
            @(negedge clk);
            m_axis_tready <= 1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            @(negedge clk);
            m_axis_tready <= 0;
        end
    end

    task write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Drive at the falling edge; a back-to-back word may raise valid at the
    // same falling edge that dropped it
    task send_pose(pose_t p, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        repeat (gap) @(negedge clk);
        s_axis_tdata = {p.qz, p.qy, p.qx, p.qw, p.tz, p.ty, p.tx};
        s_axis_tvalid = 1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_pose(p);
        @(negedge clk);
        s_axis_tvalid = 0;
    endtask

    // Hold until every pending word has come out
    task drain;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function logic [15:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'(int'($urandom_range(0, 32768)) - 16384);
            3: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 16000)) - 8000);
        endcase
    endfunction

    function pose_t rand_pose();
        pose_t p;
        p.tx = ($urandom_range(0, 7) == 0) ? $urandom : int'($urandom_range(0, 2000000)) - 1000000;
        p.ty = $urandom;
        p.tz = ($urandom_range(0, 7) == 0) ? $urandom : int'($urandom_range(0, 2000000)) - 1000000;
        p.qw = rand_q();
        p.qx = rand_q();
        p.qy = rand_q();
        p.qz = rand_q();
        return p;
    endfunction

    // Pure yaw quaternion for angle a (radians)
    function pose_t yaw_pose(real a);
        pose_t p;
        p = rand_pose();
        p.qw = 16'($rtoi(16384.0 * $cos(a / 2.0)));
        p.qx = '0;
        p.qy = 16'($rtoi(16384.0 * $sin(a / 2.0)));
        p.qz = '0;
        return p;
    endfunction

    initial
    begin
        pose_t p;
        real ang;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, negative cosine operand
        p = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 16384, 0, 0, 0};
        send_pose(p);
        p = '{32'h80000000, 32'h7fffffff, 32'h80000000, 0, 16384, 0, 0};
        send_pose(p);
        p = '{0, 0, 0, 0, 11585, 11585, 0};
        send_pose(p);
        p = '{0, -1, 0, 0, 0, 16384, 0};
        send_pose(p);
        p = '{5, 6, 7, 0, 0, -16384, 0};
        send_pose(p);
        p = '{1, 2, 3, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        send_pose(p);
        p = '{32'hffffffff, 0, 32'hffffffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
        send_pose(p);
        p = '{0, 0, 0, -16384, 0, 0, 16384};
        send_pose(p);
        for (int i = 0; i < 8; i++) send_pose(yaw_pose(-3.1 + 0.8 * i));
        for (int i = 0; i < 6; i++) send_pose(yaw_pose((i % 2) ? 3.1 : -3.1));
        drain();

        // Extreme register settings, including out-of-list index
        write_reg(CFG_MOUNT_X, 19'h40000);
        write_reg(CFG_MOUNT_Y, 19'h3ffff);
        write_reg(CFG_THRESHOLD, 19'd0);
        write_reg(2'd3, 19'h7ffff);
        for (int i = 0; i < 60; i++) send_pose(rand_pose());
        drain();
        write_reg(CFG_MOUNT_X, 19'h3ffff);
        write_reg(CFG_MOUNT_Y, 19'h40000);
        write_reg(CFG_THRESHOLD, 19'h7ffff);
        for (int i = 0; i < 60; i++) send_pose(rand_pose());
        drain();
        write_reg(CFG_MOUNT_X, 19'h6_5e26);
        write_reg(CFG_MOUNT_Y, 19'd20000);
        write_reg(CFG_THRESHOLD, 19'd196608);

        // Steady spin drives the turn count; mostly smooth, some noise
        ang = 0.0;
        for (int i = 0; i < 420; i++)
        begin
            if ($urandom_range(0, 9) == 0) send_pose(rand_pose(), i % 40 < 10);
            else
            begin
                ang += 0.9;
                if (ang > 3.14159) ang -= 6.28318;
                send_pose(yaw_pose(ang), i % 40 < 10);
            end
        end
        drain();
        write_reg(CFG_THRESHOLD, 19'd411775);
        for (int i = 0; i < 40; i++) send_pose(rand_pose());
        drain();
        if (sb.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/qyu_pkg.sv
rtl/qyu_cell.sv
rtl/qyu_unwrap.sv
rtl/quaternion_yaw_unwrap_base_pose.sv
rtl/qyu_checker.sv
dv/tb_quaternion_yaw_unwrap_base_pose.sv
